/* hdl/deqsw_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, codes and types for the double-ended queue with end swap.
// ----------------------------------------------------------------------------
package deqsw_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SWAP       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESP,
      ST_POP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C
   } state_type;

   typedef struct packed {
      logic     we;
      idx_type  waddr;
      data_type wdata;
      idx_type  raddr;
   } ram_req_type;

   function automatic idx_type ring_next(input idx_type i);
      return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + idx_type'(1);
   endfunction

   function automatic idx_type ring_prev(input idx_type i);
      return (i == '0) ? IDX_W'(CAPACITY - 1) : i - idx_type'(1);
   endfunction

endpackage

/* hdl/deqsw_ram.sv */
// ----------------------------------------------------------------------------
// Slot memory
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module deqsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/deqsw_ctrl.sv */
// ----------------------------------------------------------------------------
// Queue controller
// Holds the end pointers and the count, sequences memory accesses per request.
// ----------------------------------------------------------------------------
module deqsw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [deqsw_pkg::OP_W-1:0]    req_op,
   input  logic signed [31:0]            req_push_value,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_popped_value,
   output logic                          rsp_has_value,
   output logic [deqsw_pkg::STATUS_W-1:0] rsp_status,
   output logic [deqsw_pkg::COUNT_W-1:0] rsp_element_count,
   output deqsw_pkg::ram_req_type        ram_req,
   input  deqsw_pkg::data_type           ram_rdata
);

   deqsw_pkg::state_type  state_ff, state_in;
   deqsw_pkg::idx_type    front_ff, front_in;
   deqsw_pkg::idx_type    back_ff, back_in;
   deqsw_pkg::cnt_type    occ_ff, occ_in;
   deqsw_pkg::data_type   hold_ff, hold_in;
   deqsw_pkg::status_type status_ff, status_in;
   logic                  pop_ff, pop_in;
   logic                  full;
   logic                  empty;
   deqsw_pkg::idx_type    last_idx;

   assign full     = (occ_ff == deqsw_pkg::CNT_W'(deqsw_pkg::CAPACITY));
   assign empty    = (occ_ff == '0);
   assign last_idx = deqsw_pkg::ring_prev(back_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= deqsw_pkg::ST_IDLE;
         front_ff  <= '0;
         back_ff   <= '0;
         occ_ff    <= '0;
         status_ff <= deqsw_pkg::STATUS_OK;
         pop_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         occ_ff    <= occ_in;
         status_ff <= status_in;
         pop_ff    <= pop_in;
      end
      hold_ff <= hold_in;
   end

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      occ_in        = occ_ff;
      hold_in       = hold_ff;
      status_in     = status_ff;
      pop_in        = pop_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = front_ff;
      ram_req.wdata = req_push_value;
      ram_req.raddr = front_ff;
      rsp_valid     = 1'b0;
      case (state_ff)
         deqsw_pkg::ST_IDLE: begin
            if (start) begin
               pop_in    = 1'b0;
               status_in = deqsw_pkg::STATUS_OK;
               state_in  = deqsw_pkg::ST_RESP;
               case (deqsw_pkg::op_type'(req_op))
                  deqsw_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = deqsw_pkg::STATUS_FULL;
                     end else begin
                        front_in      = deqsw_pkg::ring_prev(front_ff);
                        ram_req.we    = 1'b1;
                        ram_req.waddr = deqsw_pkg::ring_prev(front_ff);
                        occ_in        = occ_ff + deqsw_pkg::cnt_type'(1);
                     end
                  end
                  deqsw_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = deqsw_pkg::STATUS_FULL;
                     end else begin
                        back_in       = deqsw_pkg::ring_next(back_ff);
                        ram_req.we    = 1'b1;
                        ram_req.waddr = back_ff;
                        occ_in        = occ_ff + deqsw_pkg::cnt_type'(1);
                     end
                  end
                  deqsw_pkg::OP_POP_FRONT: begin
                     if (empty) begin
                        status_in = deqsw_pkg::STATUS_EMPTY;
                     end else begin
                        ram_req.raddr = front_ff;
                        front_in      = deqsw_pkg::ring_next(front_ff);
                        occ_in        = occ_ff - deqsw_pkg::cnt_type'(1);
                        pop_in        = 1'b1;
                        state_in      = deqsw_pkg::ST_POP;
                     end
                  end
                  deqsw_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        status_in = deqsw_pkg::STATUS_EMPTY;
                     end else begin
                        ram_req.raddr = last_idx;
                        back_in       = last_idx;
                        occ_in        = occ_ff - deqsw_pkg::cnt_type'(1);
                        pop_in        = 1'b1;
                        state_in      = deqsw_pkg::ST_POP;
                     end
                  end
                  deqsw_pkg::OP_SWAP: begin
                     if (!empty) begin
                        ram_req.raddr = front_ff;
                        state_in      = deqsw_pkg::ST_SWAP_A;
                     end
                  end
                  default: begin
                     state_in = deqsw_pkg::ST_RESP;
                  end
               endcase
            end
         end
         deqsw_pkg::ST_SWAP_A: begin
            hold_in       = ram_rdata;
            ram_req.raddr = last_idx;
            state_in      = deqsw_pkg::ST_SWAP_B;
         end
         deqsw_pkg::ST_SWAP_B: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = front_ff;
            ram_req.wdata = ram_rdata;
            state_in      = deqsw_pkg::ST_SWAP_C;
         end
         deqsw_pkg::ST_SWAP_C: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = last_idx;
            ram_req.wdata = hold_ff;
            rsp_valid     = 1'b1;
            state_in      = deqsw_pkg::ST_IDLE;
         end
         deqsw_pkg::ST_RESP, deqsw_pkg::ST_POP: begin
            rsp_valid = 1'b1;
            state_in  = deqsw_pkg::ST_IDLE;
         end
         default: begin
            state_in = deqsw_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != deqsw_pkg::ST_IDLE);
   assign rsp_popped_value  = pop_ff ? ram_rdata : '0;
   assign rsp_has_value     = pop_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = deqsw_pkg::COUNT_W'(occ_ff);

endmodule

/* hdl/double_ended_queue_swap_ends.sv */
// A push, a pop, a flagged beat, an unused op or a swap of an empty deque gives its result
// in the cycle after acceptance; a swap of a non-empty deque steps through ST_SWAP_A,
// ST_SWAP_B and ST_SWAP_C (its two reads and two writes reach the memory one per cycle)
// and ends in ST_SWAP_C. Busy is high until the result cycle ends; only then is a beat taken.
// Reset clears the pointers, the count and the controller; the slot memory is not cleared.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// Double-ended queue with end swap
// Bounded deque of 32-bit words in a ring memory with push, pop and swap.
// ----------------------------------------------------------------------------
module double_ended_queue_swap_ends (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [deqsw_pkg::OP_W-1:0]     req_op,
   input  logic signed [31:0]             req_push_value,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_popped_value,
   output logic                           rsp_has_value,
   output logic [deqsw_pkg::STATUS_W-1:0] rsp_status,
   output logic [deqsw_pkg::COUNT_W-1:0]  rsp_element_count
);

   deqsw_pkg::ram_req_type ram_req;
   deqsw_pkg::data_type    ram_rdata;

   deqsw_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_has_value     (rsp_has_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .ram_req           (ram_req),
      .ram_rdata         (ram_rdata)
   );

   deqsw_ram #(
      .WIDTH (deqsw_pkg::DATA_W),
      .DEPTH (deqsw_pkg::CAPACITY),
      .AW    (deqsw_pkg::IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule

/* hdl/deqsw_chk.sv */
// ----------------------------------------------------------------------------
// Port checker
// Checks result beats of the double-ended queue as seen on its ports.
// ----------------------------------------------------------------------------
module deqsw_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic signed [31:0]             rsp_popped_value,
   input logic                           rsp_has_value,
   input logic [deqsw_pkg::STATUS_W-1:0] rsp_status,
   input logic [deqsw_pkg::COUNT_W-1:0]  rsp_element_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deqsw_pkg::STATUS_FULL) |->
         (rsp_element_count == deqsw_pkg::COUNT_W'(deqsw_pkg::CAPACITY)))
      else $error("full status with count below capacity");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deqsw_pkg::STATUS_EMPTY) |->
         (rsp_element_count == '0 && !rsp_has_value && rsp_popped_value == '0))
      else $error("empty status with data or nonzero count");

endmodule

bind double_ended_queue_swap_ends deqsw_chk u_deqsw_chk (.*);

/* sim/deqsw_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue scoreboard
// Tracks the contents of the deque for every accepted request beat and
// checks each response beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package deqsw_scoreboard_pkg;

   import deqsw_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] popped_value;
      logic                     has_value;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       element_count;
   } deque_outcome_t;

   class deque_scoreboard;

      data_type       slots [CAPACITY];
      int unsigned    head;
      int unsigned    tail;
      int unsigned    held;
      deque_outcome_t outcome_q [$];
      int             errors;
      int             push_count;
      int             pop_count;
      int             full_drops;
      int             empty_pops;
      int             swap_count;
      int             ignored_count;
      int             max_held;

      function new();
         head = 0;
         tail = 0;
         held = 0;
         errors = 0;
         push_count = 0;
         pop_count = 0;
         full_drops = 0;
         empty_pops = 0;
         swap_count = 0;
         ignored_count = 0;
         max_held = 0;
      endfunction

      function int unsigned wrap_up(int unsigned i);
         return (i + 1 >= CAPACITY) ? 0 : i + 1;
      endfunction

      function int unsigned wrap_down(int unsigned i);
         return (i == 0) ? CAPACITY - 1 : i - 1;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
         deque_outcome_t o;
         int unsigned    last;
         data_type       a;
         o.popped_value = '0;
         o.has_value = 1'b0;
         o.status = STATUS_OK;
         if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (held >= CAPACITY) begin
               o.status = STATUS_FULL;
               full_drops++;
            end else if (op == OP_PUSH_FRONT) begin
               head = wrap_down(head);
               slots[head] = value;
               held++;
               push_count++;
            end else begin
               slots[tail] = value;
               tail = wrap_up(tail);
               held++;
               push_count++;
            end
         end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (held == 0) begin
               o.status = STATUS_EMPTY;
               empty_pops++;
            end else if (op == OP_POP_FRONT) begin
               o.popped_value = slots[head];
               head = wrap_up(head);
               held--;
               o.has_value = 1'b1;
               pop_count++;
            end else begin
               tail = wrap_down(tail);
               o.popped_value = slots[tail];
               held--;
               o.has_value = 1'b1;
               pop_count++;
            end
         end else if (op == OP_SWAP) begin
            swap_count++;
            if (held != 0) begin
               last = wrap_down(tail);
               a = slots[head];
               slots[head] = slots[last];
               slots[last] = a;
            end
         end else begin
            ignored_count++;
         end
         if (held > max_held) max_held = held;
         o.element_count = COUNT_W'(held);
         outcome_q.push_back(o);
      endfunction

      function void check_response(logic signed [DATA_W-1:0] popped_value,
                                   logic has_value, logic [STATUS_W-1:0] status,
                                   logic [COUNT_W-1:0] element_count);
         deque_outcome_t o;
         if (outcome_q.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         o = outcome_q.pop_front();
         if (popped_value !== o.popped_value) begin
            $error("popped_value: expected %0d, got %0d", o.popped_value, popped_value);
            errors++;
         end
         if (has_value !== o.has_value) begin
            $error("has_value: expected %0d, got %0d", o.has_value, has_value);
            errors++;
         end
         if (status !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, status);
            errors++;
         end
         if (element_count !== o.element_count) begin
            $error("element_count: expected %0d, got %0d", o.element_count, element_count);
            errors++;
         end
      endfunction

   endclass

endpackage

/* sim/double_ended_queue_swap_ends_test.sv */
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, swap and unused request beats with random gaps and checks
// every response beat against a scoreboard that mirrors the deque contents.
// ----------------------------------------------------------------------------
module double_ended_queue_swap_ends_test;

   timeunit 1ns;
   timeprecision 1ps;

   import deqsw_pkg::*;
   import deqsw_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 380;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [OP_W-1:0]         req_op;
   logic signed [31:0]      req_push_value;
   logic                    rsp_valid;
   logic signed [31:0]      rsp_popped_value;
   logic                    rsp_has_value;
   logic [STATUS_W-1:0]     rsp_status;
   logic [COUNT_W-1:0]      rsp_element_count;

   deque_scoreboard         deque_sb;
   int                      cycles = 0;

   double_ended_queue_swap_ends dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_has_value     (rsp_has_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      deque_sb = new();
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         deque_sb.check_response(rsp_popped_value, rsp_has_value, rsp_status,
                                 rsp_element_count);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [31:0] value);
      start <= 1'b1;
      req_op <= op;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      deque_sb.note_request(op, value);
   endtask

   task automatic idle_sender(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) begin
            do @(posedge clock); while (busy);
         end
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (deque_sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 32'sh00000000;
         3:       return 32'shffffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int mode);
      int r;
      int push_lim;
      int pop_lim;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            push_lim = 70;
            pop_lim = 88;
         end
         1: begin
            push_lim = 20;
            pop_lim = 85;
         end
         default: begin
            push_lim = 42;
            pop_lim = 82;
         end
      endcase
      if (r < push_lim) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < pop_lim) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      if (r < 97) return OP_SWAP;
      return OP_W'($urandom_range(5, 7));
   endfunction

   task automatic run_phase(input int items, input int idle_pct);
      int sent;
      int mode;
      int run_len;
      sent = 0;
      while (sent < items) begin
         mode = $urandom_range(0, 2);
         run_len = $urandom_range(5, 40);
         repeat (run_len) begin
            while ($urandom_range(0, 99) < idle_pct) idle_sender(1);
            send_request(pick_op(mode), pick_value());
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = '0;
      req_push_value = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_POP_FRONT, 32'sd5);
      send_request(OP_POP_BACK, 32'sd6);
      send_request(OP_SWAP, 32'sd7);
      send_request(OP_W'(5), 32'sh12345678);
      send_request(OP_W'(6), 32'sh7fffffff);
      send_request(OP_W'(7), 32'sh80000000);
      send_request(OP_PUSH_BACK, 32'sh7fffffff);
      send_request(OP_SWAP, 32'sd0);
      send_request(OP_POP_FRONT, 32'sd0);
      send_request(OP_PUSH_FRONT, 32'sh80000000);
      send_request(OP_PUSH_BACK, 32'sd0);
      send_request(OP_PUSH_BACK, -32'sd1);
      send_request(OP_SWAP, 32'sd0);
      send_request(OP_POP_FRONT, 32'sd0);
      send_request(OP_POP_BACK, 32'sd0);
      send_request(OP_POP_BACK, 32'sd0);
      send_request(OP_POP_BACK, 32'sd0);
      wait_drained();

      run_phase(PHASE_ITEMS, 28);
      wait_drained();
      run_phase(PHASE_ITEMS, 51);
      wait_drained();
      run_phase(PHASE_ITEMS, 0);
      wait_drained();

      repeat (10) @(posedge clock);
      $display("pushes %0d, pops %0d, swaps %0d, unused ops %0d",
               deque_sb.push_count, deque_sb.pop_count, deque_sb.swap_count,
               deque_sb.ignored_count);
      $display("dropped when full %0d, pops on empty %0d, deepest fill %0d",
               deque_sb.full_drops, deque_sb.empty_pops, deque_sb.max_held);
      if (deque_sb.errors == 0 && deque_sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/deqsw_pkg.sv
hdl/deqsw_ram.sv
hdl/deqsw_ctrl.sv
hdl/double_ended_queue_swap_ends.sv
hdl/deqsw_chk.sv
sim/deqsw_scoreboard_pkg.sv
sim/double_ended_queue_swap_ends_test.sv
